[src/set_assoc_lru_cache_hit_model_assert.svh]
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_HIT_MODEL_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_HIT_MODEL_ASSERT_SVH

// Check a property outside of reset.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/salc_pkg.sv]
`default_nettype none

package salc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned LINE_OFF_BITS = 5;
  localparam int unsigned LINE_W        = ADDR_W - LINE_OFF_BITS;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ALLOC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PF_MODE = 1'd1;

  localparam logic [1:0] PF_NONE   = 2'd0;
  localparam logic [1:0] PF_ALWAYS = 2'd1;
  localparam logic [1:0] PF_MISS   = 2'd2;

  localparam logic OP_STORE = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_PFRD  = 5'b01000,
    S_PFUPD = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    A_CLR = 2'd0,
    A_IN  = 2'd1,
    A_DEM = 2'd2,
    A_PF  = 2'd3
  } addr_sel_e;

  typedef struct packed {
    logic      ld_in;
    logic      ram_re;
    logic      ram_we;
    addr_sel_e addr_sel;
    logic      upd_pf;
    logic      ld_out;
    logic      clr;
  } cmd_t;

  typedef struct packed {
    logic need_pf;
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[src/set_assoc_lru_cache_hit_model.sv]
// Tag-only model of a set-associative cache (SETS x WAYS, 32-byte lines, SETS a power of
// two) with true LRU replacement and optional next-line prefetch. Each input word is a load
// or store address; the block returns one word telling whether the demand line was present.
// After reset the block sweeps its tag memory, one set a cycle, before it takes the first
// word (configuration writes are taken at any time). Each set row lives in one single-port
// memory with registered read, so every lookup is a read followed by a write; a next-line
// prefetch adds a second read and write for the following line.
`default_nettype none

module set_assoc_lru_cache_hit_model #(
  parameter int unsigned WAYS = 4,
  parameter int unsigned SETS = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration port
  input  wire logic                              cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // access words
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              in_opcode_i,
  input  wire logic [salc_pkg::ADDR_W-1:0]       in_address_i,
  // hit/miss words
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_hit_o
);
  import salc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequence clear, demand lookup and prefetch lookup
  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold tags, valid bits and LRU ranks; register the result word
  salc_dp #(.WAYS(WAYS), .SETS(SETS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_opcode_i  (in_opcode_i),
    .in_address_i (in_address_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_hit_o    (out_hit_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

`default_nettype wire

[src/salc_ram.sv]
`default_nettype none

module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    re_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

[src/salc_ctrl.sv]
`default_nettype none

module salc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire salc_pkg::status_t sts_i,
  output salc_pkg::cmd_t         cmd_o
);
  import salc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.addr_sel = A_CLR;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.clr    = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.addr_sel = A_IN;
        if (in_valid_i) begin
          cmd_o.ld_in  = 1'b1;
          cmd_o.ram_re = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.addr_sel = A_DEM;
        // hold the read row until the output register frees up
        if (!sts_i.out_busy) begin
          cmd_o.ram_we = 1'b1;
          cmd_o.ld_out = 1'b1;
          state_d      = sts_i.need_pf ? S_PFRD : S_IDLE;
        end
      end
      S_PFRD: begin
        cmd_o.addr_sel = A_PF;
        cmd_o.ram_re   = 1'b1;
        state_d        = S_PFUPD;
      end
      S_PFUPD: begin
        cmd_o.addr_sel = A_PF;
        cmd_o.ram_we   = 1'b1;
        cmd_o.upd_pf   = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/salc_dp.sv]
`default_nettype none

module salc_dp #(
  parameter int unsigned WAYS = 4,
  parameter int unsigned SETS = 128
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                  in_opcode_i,
  input  wire logic [salc_pkg::ADDR_W-1:0]           in_address_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic                                       out_hit_o,
  input  wire salc_pkg::cmd_t                        cmd_i,
  output salc_pkg::status_t                          sts_o
);
  import salc_pkg::*;

  localparam int unsigned IDX_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned TAG_W    = LINE_W - SET_BITS;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RV_OFF   = WAYS * RANK_W;
  localparam int unsigned TG_OFF   = WAYS * (RANK_W + 1);
  localparam int unsigned ROW_W    = WAYS * (TAG_W + 1 + RANK_W);
  localparam logic [LINE_W-1:0] SET_MASK = LINE_W'(SETS - 1);
  localparam logic [RANK_W-1:0] MRU      = RANK_W'(WAYS - 1);

  logic              alloc_q;
  logic [1:0]        pf_mode_q;
  logic              op_q;
  logic [LINE_W-1:0] dem_line_q;
  logic [LINE_W-1:0] pf_line_q;
  logic              out_valid_q;
  logic              hit_q;
  logic [IDX_W-1:0]  clr_cnt_q;

  logic [IDX_W-1:0]  ram_addr;
  logic [ROW_W-1:0]  rdata, wdata, clr_row, new_row;
  logic [LINE_W-1:0] in_line;
  logic [TAG_W-1:0]  upd_tag;
  logic              fill, hit, do_upd;
  logic [RANK_W-1:0] hit_way, lru_way, tgt, tgt_rank;
  logic [TAG_W-1:0]  r_tag  [WAYS];
  logic              r_val  [WAYS];
  logic [RANK_W-1:0] r_rank [WAYS];

  assign in_line = in_address_i[ADDR_W-1:LINE_OFF_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q   <= 1'b1;
      pf_mode_q <= PF_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALLOC:   alloc_q   <= cfg_data_i[0];
        REG_PF_MODE: pf_mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q       <= in_opcode_i;
      dem_line_q <= in_line;
      pf_line_q  <= in_line + LINE_W'(1);
    end
    if (cmd_i.ld_out) begin
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd_i.addr_sel)
      A_CLR:   ram_addr = clr_cnt_q;
      A_IN:    ram_addr = IDX_W'(in_line & SET_MASK);
      A_DEM:   ram_addr = IDX_W'(dem_line_q & SET_MASK);
      A_PF:    ram_addr = IDX_W'(pf_line_q & SET_MASK);
      default: ram_addr = clr_cnt_q;
    endcase
  end

  salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk_i   (clk_i),
    .re_i    (cmd_i.ram_re),
    .we_i    (cmd_i.ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // lookup and true-LRU update of one set row
  always_comb begin
    upd_tag = cmd_i.upd_pf ? TAG_W'(pf_line_q >> SET_BITS) : TAG_W'(dem_line_q >> SET_BITS);
    fill    = cmd_i.upd_pf | !(op_q == OP_STORE && !alloc_q);
    hit     = 1'b0;
    hit_way = '0;
    lru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      r_rank[w] = rdata[w*RANK_W +: RANK_W];
      r_val[w]  = rdata[RV_OFF + w];
      r_tag[w]  = rdata[TG_OFF + w*TAG_W +: TAG_W];
      if (r_val[w] && r_tag[w] == upd_tag) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (r_rank[w] == '0) begin
        lru_way = RANK_W'(w);
      end
    end
    tgt      = hit ? hit_way : lru_way;
    tgt_rank = r_rank[tgt];
    do_upd   = hit | fill;
    new_row  = rdata;
    clr_row  = '0;
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*RANK_W +: RANK_W] = RANK_W'(w);
      if (do_upd) begin
        if (RANK_W'(w) == tgt) begin
          new_row[w*RANK_W +: RANK_W] = MRU;
          if (!hit) begin
            new_row[RV_OFF + w]              = 1'b1;
            new_row[TG_OFF + w*TAG_W +: TAG_W] = upd_tag;
          end
        end else if (r_rank[w] > tgt_rank) begin
          new_row[w*RANK_W +: RANK_W] = r_rank[w] - RANK_W'(1);
        end
      end
    end
  end

  assign wdata          = cmd_i.clr ? clr_row : new_row;
  assign sts_o.need_pf  = (pf_mode_q == PF_ALWAYS) || (pf_mode_q == PF_MISS && !hit);
  assign sts_o.clr_last = (clr_cnt_q == IDX_W'(SETS - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_hit_o      = hit_q;

endmodule

`default_nettype wire

[src/salc_checker.sv]
`default_nettype none
`include "set_assoc_lru_cache_hit_model_assert.svh"

module salc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            in_opcode_i,
  input wire logic [salc_pkg::ADDR_W-1:0]     in_address_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic                            out_hit_o
);

  `SALC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_hit_o), "result word dropped or changed while stalled")
  `SALC_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "second word taken during a lookup")
  `SALC_ASSERT(a_result_latency, $rose(out_valid_o) |-> !$past(in_ready_o), "result word without a finished lookup")
  `SALC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_ready_o, "handshake active in reset")

endmodule

bind set_assoc_lru_cache_hit_model salc_checker u_salc_checker (.*);

`default_nettype wire
